### sv/band_from_frequency_assert.svh
`ifndef BAND_FROM_FREQUENCY_ASSERT_SVH
`define BAND_FROM_FREQUENCY_ASSERT_SVH

// The condition implies the expression in the same cycle, outside reset.
`define BFF_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("band lookup check failed");

// The condition implies the expression in the next cycle, outside reset.
`define BFF_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("band lookup pipeline check failed");

`endif

### sv/bff_pkg.sv
package bff_pkg;

   // Table geometry and field widths.
   localparam int ROM_SIZE         = 32;
   localparam int BAND_ENTRIES_DEF = 32;
   localparam int IDX_W            = $clog2(ROM_SIZE);
   localparam int FREQ_W           = 32;
   localparam int KHZ_W            = 23;
   localparam int BAND_W           = 7;
   localparam int OFFSET_W         = 32;
   localparam int HZ_PER_KHZ       = 1000;

   // Division by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38.
   // The error term stays below one for every 32-bit input.
   localparam int RECIP_W   = 29;
   localparam int KHZ_SHIFT = 38;
   localparam int PROD_W    = FREQ_W + RECIP_W;
   localparam logic [RECIP_W-1:0] KHZ_RECIP = 29'd274877907;

   // Reduction tree shape: groups are reduced in the first tree stage.
   localparam int GROUPS     = 4;
   localparam int GROUP_SIZE = ROM_SIZE / GROUPS;

   typedef struct packed {
      logic [BAND_W-1:0] band;
      logic [KHZ_W-1:0]  ul_min;
      logic [KHZ_W-1:0]  dl_min;
      logic [KHZ_W-1:0]  dl_max;
   } band_row_type;

   typedef band_row_type band_rom_type [ROM_SIZE];
   typedef logic signed [OFFSET_W-1:0] offset_tab_type [ROM_SIZE];
   typedef logic [KHZ_W-1:0] centre_tab_type [ROM_SIZE];

   // One candidate of the nearest-centre search.
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [KHZ_W-1:0] gap;
   } cand_type;

   typedef cand_type [ROM_SIZE-1:0] cand_vec_type;
   typedef cand_type [GROUPS-1:0]   cand_grp_type;

   // Band, uplink min, downlink min, downlink max, all in kHz.
   localparam band_rom_type BAND_ROM = '{
      '{7'd1,  23'd1920000, 23'd2110000, 23'd2170000},
      '{7'd2,  23'd1850000, 23'd1930000, 23'd1990000},
      '{7'd3,  23'd1710000, 23'd1805000, 23'd1880000},
      '{7'd5,  23'd824000,  23'd869000,  23'd894000},
      '{7'd7,  23'd2500000, 23'd2620000, 23'd2690000},
      '{7'd8,  23'd880000,  23'd925000,  23'd960000},
      '{7'd12, 23'd698000,  23'd728000,  23'd746000},
      '{7'd20, 23'd832000,  23'd791000,  23'd821000},
      '{7'd25, 23'd1850000, 23'd1930000, 23'd1995000},
      '{7'd28, 23'd703000,  23'd758000,  23'd813000},
      '{7'd34, 23'd2010000, 23'd2010000, 23'd2025000},
      '{7'd38, 23'd2570000, 23'd2570000, 23'd2630000},
      '{7'd39, 23'd1880000, 23'd1880000, 23'd1920000},
      '{7'd40, 23'd2300000, 23'd2300000, 23'd2400000},
      '{7'd41, 23'd2496000, 23'd2496000, 23'd2690000},
      '{7'd50, 23'd1432000, 23'd1432000, 23'd1517000},
      '{7'd51, 23'd1427000, 23'd1427000, 23'd1432000},
      '{7'd66, 23'd1710000, 23'd2110000, 23'd2200000},
      '{7'd70, 23'd1695000, 23'd1995000, 23'd2020000},
      '{7'd71, 23'd663000,  23'd617000,  23'd652000},
      '{7'd74, 23'd1427000, 23'd1475000, 23'd1518000},
      '{7'd75, 23'd0,       23'd1432000, 23'd1517000},
      '{7'd76, 23'd0,       23'd1427000, 23'd1432000},
      '{7'd77, 23'd3300000, 23'd3300000, 23'd4200000},
      '{7'd78, 23'd3300000, 23'd3300000, 23'd3800000},
      '{7'd79, 23'd4400000, 23'd4400000, 23'd5000000},
      '{7'd80, 23'd1710000, 23'd0,       23'd0},
      '{7'd81, 23'd860000,  23'd0,       23'd0},
      '{7'd82, 23'd832000,  23'd0,       23'd0},
      '{7'd83, 23'd703000,  23'd0,       23'd0},
      '{7'd84, 23'd1920000, 23'd0,       23'd0},
      '{7'd86, 23'd1710000, 23'd0,       23'd0}
   };

   // Uplink-minus-downlink offset in Hz for every row, built at elaboration.
   function automatic offset_tab_type offset_table();
      offset_tab_type t;
      int d;
      for (int i = 0; i < ROM_SIZE; i++) begin
         d    = int'(BAND_ROM[i].ul_min) - int'(BAND_ROM[i].dl_min);
         t[i] = OFFSET_W'(d * HZ_PER_KHZ);
      end
      return t;
   endfunction

   // Downlink range centre of every row, rounded down.
   function automatic centre_tab_type centre_table();
      centre_tab_type t;
      logic [KHZ_W:0] s;
      for (int i = 0; i < ROM_SIZE; i++) begin
         s    = {1'b0, BAND_ROM[i].dl_min} + {1'b0, BAND_ROM[i].dl_max};
         t[i] = s[KHZ_W:1];
      end
      return t;
   endfunction

   localparam offset_tab_type OFFSET_TAB = offset_table();
   localparam centre_tab_type CENTRE_TAB = centre_table();

   // Keeps the earlier candidate unless the later one is found and the earlier is not, or is strictly nearer.
   function automatic cand_type cand_pick(cand_type a, cand_type b);
      if (b.found && (!a.found || (b.gap < a.gap))) begin
         return b;
      end
      return a;
   endfunction

endpackage

### sv/bff_khz_div.sv
module bff_khz_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [bff_pkg::FREQ_W-1:0] freq_hz,
   output logic                       out_valid,
   output logic [bff_pkg::KHZ_W-1:0]  freq_khz
);
   import bff_pkg::*;

   logic              valid_ff, valid_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // Reciprocal multiply; the shift is taken from the registered product.
   assign valid_in = in_valid;
   assign prod_in  = freq_hz * KHZ_RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign freq_khz  = prod_ff[KHZ_SHIFT +: KHZ_W];

endmodule

### sv/bff_band_match.sv
module bff_band_match #(
   parameter int BAND_ENTRIES = bff_pkg::BAND_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [bff_pkg::KHZ_W-1:0] freq_khz,
   output logic                      out_valid,
   output bff_pkg::cand_vec_type     cands
);
   import bff_pkg::*;

   logic         valid_ff, valid_in;
   cand_vec_type cands_ff, cands_in;

   // Range check and distance to the centre for every scanned row.
   always_comb begin
      for (int i = 0; i < ROM_SIZE; i++) begin
         cands_in[i].found = (i < BAND_ENTRIES) &&
                             (freq_khz >= BAND_ROM[i].dl_min) &&
                             (freq_khz <= BAND_ROM[i].dl_max);
         cands_in[i].idx   = IDX_W'(i);
         cands_in[i].gap   = (freq_khz >= CENTRE_TAB[i]) ? (freq_khz - CENTRE_TAB[i])
                                                         : (CENTRE_TAB[i] - freq_khz);
      end
   end

   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cands_ff <= cands_in;
      end
   end

   assign out_valid = valid_ff;
   assign cands     = cands_ff;

endmodule

### sv/bff_min_tree.sv
module bff_min_tree (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  bff_pkg::cand_vec_type cands,
   output logic                  out_valid,
   output bff_pkg::cand_type     winner
);
   import bff_pkg::*;

   logic         valid_ff, valid_in;
   cand_grp_type grp_ff, grp_in;

   // First level: nearest candidate of each group, in table order.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = cands[g * GROUP_SIZE];
         for (int k = 1; k < GROUP_SIZE; k++) begin
            grp_in[g] = cand_pick(grp_in[g], cands[g * GROUP_SIZE + k]);
         end
      end
   end

   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         grp_ff <= grp_in;
      end
   end

   // Second level: nearest of the group winners, earlier group first.
   always_comb begin
      winner = grp_ff[0];
      for (int g = 1; g < GROUPS; g++) begin
         winner = cand_pick(winner, grp_ff[g]);
      end
   end

   assign out_valid = valid_ff;

endmodule

### sv/band_from_frequency.sv
// Operating band lookup from a downlink carrier frequency.
// Each accepted request beat moves through the stage registers in order to its response beat.
// Throughput: one beat per cycle; the pipeline holds only while a response beat waits.
// The four stages are the kHz reciprocal multiply, the row compares, and two tree levels.
// Reset clears the valid bits of every stage; no table needs initialization.
module band_from_frequency #(
   parameter int BAND_ENTRIES = bff_pkg::BAND_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bff_pkg::FREQ_W-1:0]          req_downlink_freq_hz,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bff_pkg::BAND_W-1:0]          rsp_band_number,
   output logic signed [bff_pkg::OFFSET_W-1:0] rsp_uplink_offset_hz,
   output logic                                rsp_tdd_mode,
   output logic                                rsp_found
);
   import bff_pkg::*;
`include "band_from_frequency_assert.svh"

   logic                       advance;
   logic                       khz_valid;
   logic [KHZ_W-1:0]           freq_khz;
   logic                       match_valid;
   cand_vec_type               cands;
   logic                       tree_valid;
   cand_type                   winner;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [BAND_W-1:0]          rsp_band_ff, rsp_band_in;
   logic signed [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic                       rsp_frame_ff, rsp_frame_in;
   logic                       rsp_found_ff, rsp_found_in;

   // The pipeline moves whenever the output register is empty or its beat leaves.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   bff_khz_div u_khz_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .freq_hz   (req_downlink_freq_hz),
      .out_valid (khz_valid),
      .freq_khz  (freq_khz)
   );

   bff_band_match #(
      .BAND_ENTRIES (BAND_ENTRIES)
   ) u_band_match (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (khz_valid),
      .freq_khz  (freq_khz),
      .out_valid (match_valid),
      .cands     (cands)
   );

   bff_min_tree u_min_tree (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (match_valid),
      .cands     (cands),
      .out_valid (tree_valid),
      .winner    (winner)
   );

   // Look up the chosen row; a miss reports all zeros.
   always_comb begin
      rsp_valid_in  = tree_valid;
      rsp_found_in  = winner.found;
      rsp_band_in   = winner.found ? BAND_ROM[winner.idx].band : '0;
      rsp_offset_in = winner.found ? OFFSET_TAB[winner.idx] : '0;
      rsp_frame_in  = winner.found && (OFFSET_TAB[winner.idx] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_band_ff   <= rsp_band_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_frame_ff  <= rsp_frame_in;
         rsp_found_ff  <= rsp_found_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_band_number      = rsp_band_ff;
   assign rsp_uplink_offset_hz = rsp_offset_ff;
   assign rsp_tdd_mode         = rsp_frame_ff;
   assign rsp_found            = rsp_found_ff;

   // A match always names a real band number.
   `BFF_ASSERT_IMP(a_found_band, clock, reset, rsp_valid_ff && rsp_found_ff, rsp_band_ff != '0)
   // A miss reports band, offset and frame type as zero.
   `BFF_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_found_ff,
                   (rsp_band_ff == '0) && (rsp_offset_ff == '0) && !rsp_frame_ff)
   // TDD is only reported for a matched band with no duplex offset.
   `BFF_ASSERT_IMP(a_tdd_offset, clock, reset, rsp_valid_ff && rsp_frame_ff,
                   rsp_found_ff && (rsp_offset_ff == '0))
   // A beat leaving the tree while the pipeline moves lands in the output register.
   `BFF_ASSERT_NEXT(a_tree_to_out, clock, reset, tree_valid && advance, rsp_valid_ff)

endmodule
